[design/d3q7_species_bgk_collision_assert.svh]
// Assertion macros shared by the collision block.
`ifndef D3Q7_SPECIES_BGK_COLLISION_ASSERT_SVH
`define D3Q7_SPECIES_BGK_COLLISION_ASSERT_SVH
// condition holds at every edge out of reset
`define D3Q7_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define D3Q7_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[design/d3q7_pkg.sv]
// Shared constants and helpers of the D3Q7 species collision block.
package d3q7_pkg;
   localparam int VALUE_W  = 32;
   localparam int FRAC     = 24;
   localparam int CONC_W   = 35;
   localparam int K_W      = 19;
   localparam int DEN_W    = 37;
   localparam int QUO_W    = 26;
   localparam int NUM_W    = 50;
   localparam int DIV_STAGES = QUO_W;
   localparam int LANE_LAG = DIV_STAGES - 2;
   localparam int CONC_LAG = DIV_STAGES + 1;
   localparam int PIPE_DEPTH = DIV_STAGES + 4;
   localparam int LANES    = 7;
   localparam logic [30:0] TAU_RESET = 31'd1 << FRAC;
   localparam logic [DEN_W-1:0] HALF = DEN_W'(64'd1 << (FRAC - 1));
   localparam logic [DEN_W-1:0] TE_FLOOR =
      DEN_W'(((64'd501 << FRAC) + 64'd500) / 64'd1000);
   localparam logic [NUM_W-1:0] NUM_BASE = NUM_W'(64'd1 << (2 * FRAC));
   localparam logic signed [K_W-1:0] K_ONE = K_W'(32'sd1 << 14);

   function automatic logic [VALUE_W-1:0] sat42(input logic signed [41:0] v);
      logic signed [41:0] hi;
      logic signed [41:0] lo;
      hi = 42'sd2147483647;
      lo = -42'sd2147483648;
      if (v > hi) return hi[VALUE_W-1:0];
      else if (v < lo) return lo[VALUE_W-1:0];
      else return v[VALUE_W-1:0];
   endfunction
endpackage

[design/d3q7_div.sv]
// Pipelined restoring divider forming the rounded reciprocal of tau_eff.
module d3q7_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [d3q7_pkg::DEN_W-1:0]  den,
   output logic [d3q7_pkg::QUO_W-1:0]  quo
);
   import d3q7_pkg::*;

   logic [DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [DEN_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [QUO_W-1:0] q_ff   [DIV_STAGES];
   logic [NUM_W-1:0] num;

   // round(2^48 / den) as floor((2^48 + den/2) / den)
   assign num = NUM_BASE + NUM_W'(den >> 1);

   genvar s;
   generate
      for (s = 0; s < DIV_STAGES; s++) begin : g_stage
         logic [DEN_W-1:0] rem_prev;
         logic [DEN_W-1:0] den_prev;
         logic [QUO_W-1:0] low_prev;
         logic [QUO_W-1:0] q_prev;
         logic [DEN_W:0]   trial;
         logic [DEN_W-1:0] rem_in;
         logic             bit_in;
         if (s == 0) begin : g_first
            assign rem_prev = DEN_W'(num[NUM_W-1:QUO_W]);
            assign den_prev = den;
            assign low_prev = num[QUO_W-1:0];
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[s-1];
            assign den_prev = den_ff[s-1];
            assign low_prev = low_ff[s-1];
            assign q_prev   = q_ff[s-1];
         end
         always_comb begin
            trial  = {rem_prev, low_prev[QUO_W-1]};
            bit_in = trial >= {1'b0, den_prev};
            rem_in = bit_in ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= den_prev;
               low_ff[s] <= {low_prev[QUO_W-2:0], 1'b0};
               q_ff[s]   <= {q_prev[QUO_W-2:0], bit_in};
            end
         end
      end
   endgenerate

   assign quo = q_ff[DIV_STAGES-1];
endmodule

[design/d3q7_lane.sv]
// One direction lane: equilibrium, relaxation, source addition and saturation of one distribution.
module d3q7_lane (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [d3q7_pkg::CONC_W-1:0]  conc,
   input  logic signed [d3q7_pkg::K_W-1:0]     k,
   input  logic signed [d3q7_pkg::VALUE_W-1:0] f_val,
   input  logic signed [d3q7_pkg::VALUE_W-1:0] src,
   input  logic [d3q7_pkg::QUO_W-1:0]          rlx,
   output logic [d3q7_pkg::VALUE_W-1:0]        result
);
   import d3q7_pkg::*;

   typedef struct packed {
      logic signed [37:0]        d;
      logic signed [VALUE_W-1:0] f;
      logic signed [VALUE_W-1:0] s;
   } carry_type;

   logic signed [53:0]        eqp_ff;
   logic signed [VALUE_W-1:0] f4_ff;
   logic signed [VALUE_W-1:0] s4_ff;
   carry_type                 c5_ff;
   carry_type                 dly_ff [LANE_LAG];
   logic signed [63:0]        prod_ff;
   logic signed [VALUE_W-1:0] fp_ff;
   logic signed [VALUE_W-1:0] sp_ff;
   logic signed [53:0]        eqp_rnd;
   logic signed [36:0]        eq;
   logic signed [63:0]        prod_in;
   logic signed [63:0]        prod_rnd;
   logic signed [41:0]        total;

   always_comb begin
      eqp_rnd  = eqp_ff + 54'sd65536;
      eq       = eqp_rnd[53:17];
      prod_in  = $signed({38'd0, rlx}) * 64'(dly_ff[LANE_LAG-1].d);
      prod_rnd = prod_ff + 64'sd8388608;
      total    = 42'($signed(prod_rnd[63:24])) + 42'(fp_ff) + 42'(sp_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         eqp_ff  <= 54'(conc) * 54'(k);
         f4_ff   <= f_val;
         s4_ff   <= src;
         c5_ff.d <= 38'(eq) - 38'(f4_ff);
         c5_ff.f <= f4_ff;
         c5_ff.s <= s4_ff;
         dly_ff[0] <= c5_ff;
         for (int i = 1; i < LANE_LAG; i++) dly_ff[i] <= dly_ff[i-1];
         prod_ff <= prod_in;
         fp_ff   <= dly_ff[LANE_LAG-1].f;
         sp_ff   <= dly_ff[LANE_LAG-1].s;
      end
   end

   assign result = sat42(total);
endmodule

[design/d3q7_species_bgk_collision.sv]
// Top level of the D3Q7 species BGK collision pipeline.
// Usage:
//  req_* carries one lattice node word (seven distributions, velocity,
//  porosity, diffusivity, source, phase) under req_valid/req_ready.
//  rsp_* returns the seven relaxed distributions and the concentration
//  under rsp_valid/rsp_ready, in order, one result word per node word.
//  csr_wr_en/csr_wr_data load the base relaxation time; write it while idle.
//  Throughput is one node per cycle while rsp_ready does not stall the
//  pipeline. The depth is set by the 26-stage reciprocal divider for
//  1/tau_eff, which runs beside seven parallel lanes; the rsp register
//  merges the lane outputs with the concentration.
//  A stalled rsp_ready freezes the whole pipeline and drops req_ready, so no
//  word is lost; the pipeline resumes when the held result is taken.
//  Synchronous reset empties the pipeline and restores tau to 1.0.
module d3q7_species_bgk_collision (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_dist_rest,
   input  logic signed [31:0] req_dist_xpos,
   input  logic signed [31:0] req_dist_xneg,
   input  logic signed [31:0] req_dist_ypos,
   input  logic signed [31:0] req_dist_yneg,
   input  logic signed [31:0] req_dist_zpos,
   input  logic signed [31:0] req_dist_zneg,
   input  logic [47:0] req_vel_packed,
   input  logic [16:0] req_porosity,
   input  logic [19:0] req_diffusivity,
   input  logic signed [31:0] req_source,
   input  logic signed [31:0] req_phase,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_new_rest,
   output logic signed [31:0] rsp_new_xpos,
   output logic signed [31:0] rsp_new_xneg,
   output logic signed [31:0] rsp_new_ypos,
   output logic signed [31:0] rsp_new_yneg,
   output logic signed [31:0] rsp_new_zpos,
   output logic signed [31:0] rsp_new_zneg,
   output logic signed [31:0] rsp_concentration
);
   import d3q7_pkg::*;
   `include "d3q7_species_bgk_collision_assert.svh"

   logic                      en;
   logic [30:0]               tau_ff;
   logic [PIPE_DEPTH-1:0]     vld_ff;
   logic                      rsp_valid_ff;

   logic signed [VALUE_W-1:0] f1_ff [LANES];
   logic signed [VALUE_W-1:0] f2_ff [LANES];
   logic signed [VALUE_W-1:0] f3_ff [LANES];
   logic signed [CONC_W-1:0]  conc1_ff, conc2_ff, conc3_ff;
   logic signed [50:0]        pt1_ff;
   logic signed [55:0]        pt2_ff;
   logic [47:0]               vel1_ff, vel2_ff;
   logic [19:0]               dif1_ff;
   logic signed [VALUE_W-1:0] src1_ff, src2_ff;
   logic                      gas1_ff, gas2_ff;
   logic [DEN_W-1:0]          te_ff;
   logic signed [K_W-1:0]     k3_ff [LANES];
   logic signed [VALUE_W-1:0] s3_ff [LANES];
   logic [VALUE_W-1:0]        conc_dly_ff [CONC_LAG];
   logic [VALUE_W-1:0]        out_ff [LANES];
   logic [VALUE_W-1:0]        conc_out_ff;

   logic signed [VALUE_W-1:0] f_in [LANES];
   logic signed [CONC_W-1:0]  conc_in;
   logic signed [32:0]        tau_s;
   logic signed [50:0]        pt1_in;
   logic signed [50:0]        t1_rnd;
   logic signed [55:0]        t2_rnd;
   logic signed [40:0]        te_s;
   logic [DEN_W-1:0]          te_in;
   logic signed [K_W-1:0]     k_in [LANES];
   logic signed [K_W-1:0]     u4 [3];
   logic signed [32:0]        srcx;
   logic signed [32:0]        s_rest, s_dir;
   logic [QUO_W-1:0]          rlx;
   logic [VALUE_W-1:0]        lane_out [LANES];

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      f_in[0] = req_dist_rest;
      f_in[1] = req_dist_xpos;
      f_in[2] = req_dist_xneg;
      f_in[3] = req_dist_ypos;
      f_in[4] = req_dist_yneg;
      f_in[5] = req_dist_zpos;
      f_in[6] = req_dist_zneg;
      conc_in = '0;
      for (int i = 0; i < LANES; i++) conc_in = conc_in + CONC_W'(f_in[i]);
      tau_s  = $signed({2'b00, tau_ff}) - $signed(33'(HALF));
      pt1_in = 51'(tau_s) * 51'($signed({1'b0, req_porosity}));
      t1_rnd = pt1_ff + 51'sd32768;
      t2_rnd = pt2_ff + 56'sd32768;
      te_s   = 41'($signed(t2_rnd[55:16])) + $signed({4'd0, HALF});
      // tau_eff floor at 0.501
      if (te_s < $signed({4'd0, TE_FLOOR})) te_in = TE_FLOOR;
      else te_in = te_s[DEN_W-1:0];
      for (int a = 0; a < 3; a++) begin
         u4[a] = K_W'($signed(vel2_ff[16*a +: 16])) <<< 2;
      end
      k_in[0] = K_ONE <<< 1;
      for (int a = 0; a < 3; a++) begin
         k_in[1 + 2*a] = K_ONE + u4[a];
         k_in[2 + 2*a] = K_ONE - u4[a];
      end
      srcx   = 33'(src2_ff);
      s_rest = (srcx + 33'sd2) >>> 2;
      s_dir  = (srcx + 33'sd4) >>> 3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tau_ff       <= TAU_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) tau_ff <= csr_wr_data;
         if (en) begin
            vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
            rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= f_in;
         conc1_ff <= conc_in;
         pt1_ff   <= pt1_in;
         vel1_ff  <= req_vel_packed;
         dif1_ff  <= req_diffusivity;
         src1_ff  <= req_source;
         gas1_ff  <= req_phase < $signed(32'(HALF));
         f2_ff    <= f1_ff;
         conc2_ff <= conc1_ff;
         pt2_ff   <= 56'($signed(t1_rnd[50:16])) * 56'($signed({1'b0, dif1_ff}));
         vel2_ff  <= vel1_ff;
         src2_ff  <= src1_ff;
         gas2_ff  <= gas1_ff;
         f3_ff    <= f2_ff;
         conc3_ff <= conc2_ff;
         te_ff    <= te_in;
         k3_ff    <= k_in;
         s3_ff[0] <= gas2_ff ? s_rest[VALUE_W-1:0] : '0;
         for (int i = 1; i < LANES; i++) s3_ff[i] <= gas2_ff ? s_dir[VALUE_W-1:0] : '0;
         conc_dly_ff[0] <= sat42(42'(conc3_ff));
         for (int i = 1; i < CONC_LAG; i++) conc_dly_ff[i] <= conc_dly_ff[i-1];
         out_ff      <= lane_out;
         conc_out_ff <= conc_dly_ff[CONC_LAG-1];
      end
   end

   d3q7_div u_div (
      .clock (clock),
      .en    (en),
      .den   (te_ff),
      .quo   (rlx)
   );

   genvar g;
   generate
      for (g = 0; g < LANES; g++) begin : g_lane
         d3q7_lane u_lane (
            .clock  (clock),
            .en     (en),
            .conc   (conc3_ff),
            .k      (k3_ff[g]),
            .f_val  (f3_ff[g]),
            .src    (s3_ff[g]),
            .rlx    (rlx),
            .result (lane_out[g])
         );
      end
   endgenerate

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_rest      = out_ff[0];
   assign rsp_new_xpos      = out_ff[1];
   assign rsp_new_xneg      = out_ff[2];
   assign rsp_new_ypos      = out_ff[3];
   assign rsp_new_yneg      = out_ff[4];
   assign rsp_new_zpos      = out_ff[5];
   assign rsp_new_zneg      = out_ff[6];
   assign rsp_concentration = conc_out_ff;

   // te_ff only carries a live word when stage three is valid
   `D3Q7_ASSERT_ALWAYS(a_te_floor, clock, reset, !vld_ff[2] || (te_ff >= TE_FLOOR))
   `D3Q7_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, vld_ff[0])
   `D3Q7_ASSERT_NEXT(a_stall_freezes, clock, reset, !en, $stable(vld_ff))
endmodule

[tb/sv/d3q7_species_bgk_collision_checker.sv]
// Checker for the D3Q7 collision block: predicts each node word and compares results.
module d3q7_species_bgk_collision_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_dist_rest,
   input  logic [31:0] req_dist_xpos,
   input  logic [31:0] req_dist_xneg,
   input  logic [31:0] req_dist_ypos,
   input  logic [31:0] req_dist_yneg,
   input  logic [31:0] req_dist_zpos,
   input  logic [31:0] req_dist_zneg,
   input  logic [47:0] req_vel_packed,
   input  logic [16:0] req_porosity,
   input  logic [19:0] req_diffusivity,
   input  logic [31:0] req_source,
   input  logic [31:0] req_phase,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_new_rest,
   input  logic [31:0] rsp_new_xpos,
   input  logic [31:0] rsp_new_xneg,
   input  logic [31:0] rsp_new_ypos,
   input  logic [31:0] rsp_new_yneg,
   input  logic [31:0] rsp_new_zpos,
   input  logic [31:0] rsp_new_zneg,
   input  logic [31:0] rsp_concentration,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [7:0][31:0] lanes_type;

   localparam longint HALF_Q24 = 64'sd1 << 23;
   localparam longint TE_MIN = ((64'sd501 << 24) + 64'sd500) / 64'sd1000;

   logic [30:0] tau_q24;
   lanes_type   expected_lanes[$];
   string       lane_names[8] = '{"new_rest", "new_xpos", "new_xneg", "new_ypos",
                                  "new_yneg", "new_zpos", "new_zneg", "concentration"};

   function automatic longint round_shift(longint x, int s);
      return (x + (64'sd1 << (s - 1))) >>> s;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic lanes_type collide(logic [6:0][31:0] pdf, logic [47:0] vel,
                                         logic [16:0] por, logic [19:0] dif,
                                         logic [31:0] src, logic [31:0] ph,
                                         logic [30:0] tau);
      longint f[7];
      longint k[7];
      longint u[3];
      longint conc, t1, t2, te, rlx, eq, rel, s;
      bit     gas;
      lanes_type r;
      conc = 0;
      for (int i = 0; i < 7; i++) begin
         f[i] = longint'($signed(pdf[i]));
         conc += f[i];
      end
      for (int i = 0; i < 3; i++) u[i] = longint'($signed(vel[16*i +: 16]));
      t1 = round_shift((longint'(tau) - HALF_Q24) * longint'(por), 16);
      t2 = round_shift(t1 * longint'(dif), 16);
      te = HALF_Q24 + t2;
      if (te < TE_MIN) te = TE_MIN;
      rlx = ((64'sd1 << 48) + (te >> 1)) / te;
      gas = longint'($signed(ph)) < HALF_Q24;
      k[0] = 64'sd2 << 14;
      for (int i = 0; i < 3; i++) begin
         k[1 + 2*i] = (64'sd1 << 14) + 4 * u[i];
         k[2 + 2*i] = (64'sd1 << 14) - 4 * u[i];
      end
      for (int i = 0; i < 7; i++) begin
         eq  = round_shift(conc * k[i], 17);
         rel = round_shift(rlx * (eq - f[i]), 24);
         s   = gas ? round_shift(longint'($signed(src)), (i == 0) ? 2 : 3) : 0;
         r[i] = clip32(f[i] + rel + s);
      end
      r[7] = clip32(conc);
      return r;
   endfunction

   assign pending = expected_lanes.size();

   always @(posedge clock) begin
      lanes_type got, want;
      if (reset) begin
         tau_q24 <= 31'd1 << 24;
         mismatches <= 0;
         expected_lanes.delete();
      end else begin
         if (csr_wr_en) tau_q24 <= csr_wr_data;
         if (req_valid && req_ready)
            expected_lanes.push_back(collide({req_dist_zneg, req_dist_zpos, req_dist_yneg,
               req_dist_ypos, req_dist_xneg, req_dist_xpos, req_dist_rest},
               req_vel_packed, req_porosity, req_diffusivity, req_source, req_phase,
               tau_q24));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_concentration, rsp_new_zneg, rsp_new_zpos, rsp_new_yneg,
                   rsp_new_ypos, rsp_new_xneg, rsp_new_xpos, rsp_new_rest};
            if (expected_lanes.size() == 0) begin
               if (mismatches < 10) $display("unexpected result word %h", got);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_lanes.pop_front();
               if (got !== want) begin
                  if (mismatches < 10)
                     for (int i = 0; i < 8; i++)
                        if (got[i] !== want[i])
                           $display("%s: expected %h, got %h", lane_names[i],
                                    want[i], got[i]);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end
endmodule

[tb/sv/tb_d3q7_species_bgk_collision.sv]
// Testbench top for the D3Q7 collision block: stimulus, idling and verdict.
module tb_d3q7_species_bgk_collision;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [6:0][31:0] pdf;
      logic [47:0]      vel;
      logic [16:0]      por;
      logic [19:0]      dif;
      logic [31:0]      src;
      logic [31:0]      ph;
   } node_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [30:0] csr_wr_data = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_dist[7] = '{default: '0};
   logic [47:0] req_vel_packed = '0;
   logic [16:0] req_porosity = '0;
   logic [19:0] req_diffusivity = '0;
   logic [31:0] req_source = '0;
   logic [31:0] req_phase = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_lane[8];
   int          mismatches, pending;

   int tx_idle = 0, rx_idle = 0;
   bit stall_request = 0, stall_used = 0;
   int stall_left = 0;
   int quiet_cycles = 0;

   initial forever #2 clock = ~clock;

   d3q7_species_bgk_collision DUT (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_dist_rest(req_dist[0]), .req_dist_xpos(req_dist[1]),
      .req_dist_xneg(req_dist[2]), .req_dist_ypos(req_dist[3]),
      .req_dist_yneg(req_dist[4]), .req_dist_zpos(req_dist[5]),
      .req_dist_zneg(req_dist[6]), .req_vel_packed(req_vel_packed),
      .req_porosity(req_porosity), .req_diffusivity(req_diffusivity),
      .req_source(req_source), .req_phase(req_phase),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_rest(rsp_lane[0]), .rsp_new_xpos(rsp_lane[1]),
      .rsp_new_xneg(rsp_lane[2]), .rsp_new_ypos(rsp_lane[3]),
      .rsp_new_yneg(rsp_lane[4]), .rsp_new_zpos(rsp_lane[5]),
      .rsp_new_zneg(rsp_lane[6]), .rsp_concentration(rsp_lane[7]));

   d3q7_species_bgk_collision_checker u_checker (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_dist_rest(req_dist[0]), .req_dist_xpos(req_dist[1]),
      .req_dist_xneg(req_dist[2]), .req_dist_ypos(req_dist[3]),
      .req_dist_yneg(req_dist[4]), .req_dist_zpos(req_dist[5]),
      .req_dist_zneg(req_dist[6]), .req_vel_packed(req_vel_packed),
      .req_porosity(req_porosity), .req_diffusivity(req_diffusivity),
      .req_source(req_source), .req_phase(req_phase),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_rest(rsp_lane[0]), .rsp_new_xpos(rsp_lane[1]),
      .rsp_new_xneg(rsp_lane[2]), .rsp_new_ypos(rsp_lane[3]),
      .rsp_new_yneg(rsp_lane[4]), .rsp_new_zpos(rsp_lane[5]),
      .rsp_new_zneg(rsp_lane[6]), .rsp_concentration(rsp_lane[7]),
      .mismatches(mismatches), .pending(pending));

   // receiver: random backpressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (stall_request && !stall_used) begin
         stall_used <= 1;
         stall_left <= 300;
         rsp_ready  <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   function automatic node_type rand_node();
      node_type n;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 7; i++) n.pdf[i] = rand32();
      n.vel = 48'({$urandom(), $urandom()});
      n.por = 17'($urandom());
      n.dif = 20'($urandom());
      n.src = rand32();
      n.ph  = rand32();
      if (kind < 6) begin
         // physical-looking node: modest distributions, small velocity
         for (int i = 0; i < 7; i++)
            n.pdf[i] = $urandom_range(0, 32'h0100_0000) - 32'h0008_0000;
         for (int i = 0; i < 3; i++)
            n.vel[16*i +: 16] = 16'($urandom_range(0, 4000) - 2000);
         n.por = 17'($urandom_range(0, 65536));
         n.dif = 20'($urandom_range(0, 131072));
         n.src = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         n.ph  = $urandom_range(0, 1) ? 32'h0100_0000 : $urandom_range(0, 32'h0100_0000);
      end else if (kind < 8) begin
         n.por = 17'($urandom_range(0, 131071));
         for (int i = 0; i < 7; i++) n.pdf[i] = $signed(n.pdf[i]) >>> 4;
      end
      return n;
   endfunction

   task automatic send_node(node_type n);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      for (int i = 0; i < 7; i++) req_dist[i] <= n.pdf[i];
      req_vel_packed  <= n.vel;
      req_porosity    <= n.por;
      req_diffusivity <= n.dif;
      req_source      <= n.src;
      req_phase       <= n.ph;
      req_valid       <= 1;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tau(logic [30:0] v);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   task automatic directed_nodes();
      node_type b, n;
      for (int i = 0; i < 7; i++) b.pdf[i] = 32'h0020_0000;
      b.vel = '0; b.por = 17'd65536; b.dif = 20'd65536;
      b.src = 32'h0100_0000; b.ph = 32'h0;
      send_node(b);
      n = b; n.ph = 32'h0080_0000; send_node(n);          // exactly one half: liquid
      n = b; n.ph = 32'h007f_ffff; send_node(n);          // just below one half: gas
      n = b; n.ph = 32'h7fff_ffff; n.src = 32'h7fff_ffff; send_node(n);
      n = b; n.src = 32'h8000_0000; send_node(n);
      n = b; n.src = 32'h7fff_ffff; send_node(n);
      n = b; n.pdf = '{default: 32'h7fff_ffff}; send_node(n);  // concentration overflow
      n = b; n.pdf = '{default: 32'h8000_0000}; send_node(n);
      n = b; n.pdf = '{default: 32'h0}; send_node(n);
      n = b; n.vel = {3{16'h7fff}}; send_node(n);
      n = b; n.vel = {3{16'h8000}}; send_node(n);
      n = b; n.vel = {16'h1234, 16'h8000, 16'h7fff}; send_node(n);
      n = b; n.por = 17'h1ffff; send_node(n);             // porosity above one
      n = b; n.por = 17'd0; send_node(n);
      n = b; n.dif = 20'hfffff; send_node(n);
      n = b; n.dif = 20'd0; send_node(n);
      n = b; n.por = 17'h1ffff; n.dif = 20'hfffff; send_node(n);
      n = b; n.ph = 32'h8000_0000; send_node(n);
      n = b; n.pdf = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'h7fff_ffff, 32'h8000_0000, 32'h1};
      n.vel = {3{16'h7fff}}; send_node(n);
      n.pdf = '{default: 32'hffff_ffff}; n.vel = '1; n.por = '1; n.dif = '1;
      n.src = '1; n.ph = '1; send_node(n);
   endtask

   logic [30:0] tau_plan[6];

   initial begin
      tau_plan = '{31'd1 << 24, 31'd0, 31'h7fff_ffff, 31'd12582912, 31'd8396800, 31'd0};
      tau_plan[5] = 31'($urandom());
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      tx_idle = 10; rx_idle = 66;
      directed_nodes();
      drain();
      for (int p = 0; p < 6; p++) begin
         write_tau(tau_plan[p]);
         if (p < 2) begin tx_idle = 10; rx_idle = 66; end
         else if (p < 4) begin tx_idle = 66; rx_idle = 10; end
         else begin tx_idle = 0; rx_idle = 0; end
         for (int j = 0; j < 255; j++) begin
            if (p == 5 && j == 40) stall_request = 1;
            send_node(rand_node());
         end
         // sender pauses here until every result is back
         drain();
      end
      if (mismatches == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
